>>> hdl/hdtn_pkg.sv
// Shared types and constants for the Hermitian tridiagonal norm block.
// Used by every module under hdl; depends on nothing.
package hdtn_pkg;

	localparam int ValW   = 24;
	localparam int MagW   = 25;
	localparam int NormW  = 30;
	localparam int SumW   = 64;
	localparam int RootW  = 32;
	localparam int QDepth = 2;
	localparam int QCntW  = $clog2(QDepth + 1);
	localparam int QPtrW  = $clog2(QDepth);

	localparam logic [1:0] MODE_MAX  = 2'd0;
	localparam logic [1:0] MODE_ONE  = 2'd1;
	localparam logic [1:0] MODE_FROB = 2'd2;

	localparam logic [NormW-1:0] NormMax = '1;

	// one classified row as it waits between the front and back parts
	typedef struct packed {
		logic [ValW-1:0] dmag;
		logic [ValW-1:0] re_mag;
		logic [ValW-1:0] im_mag;
		logic            last;
		logic [1:0]      mode;
	} row_t;

	function automatic logic [ValW-1:0] abs_val(input logic [ValW-1:0] v);
		abs_val = v[ValW-1] ? ValW'(-v) : v;
	endfunction

endpackage

>>> hdl/hermitian_tridiagonal_norm.sv
// Top level of the Hermitian tridiagonal matrix norm block.
// Depends on hdtn_pkg, hdtn_front, hdtn_queue, hdtn_back and hdtn_isqrt.
//
// channel   direction  word
// s_*       in         one row: diag, off-diagonal re/im, tlast = last row
// m_*       out        the norm, emitted once per matrix
// cfg_*     in         norm mode register
//
// A row other than the last waits in the back part for the square-root unit, which yields
// one root bit per cycle for the off-diagonal magnitude. A last row skips that root, but in
// Frobenius mode waits for the final root instead. The two-row queue lets rows arrive while
// the back part works; s_tready drops when it is full. A stalled result waits in the output
// register. Reset clears the control and norm state; the data registers are not reset.
module hermitian_tridiagonal_norm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // diag_value, off_diag_re, off_diag_im
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // norm_value, then two zero bits
);
	import hdtn_pkg::*;

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_valid;
	row_t             wr_row;
	row_t             rd_row;
	logic [QCntW-1:0] q_count;

	hdtn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_row     (wr_row)
	);

	hdtn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_row   (wr_row),
		.pop      (q_pop),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_row   (rd_row),
		.count    (q_count)
	);

	hdtn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_row    (rd_row),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == QCntW'(QDepth)) |-> !s_tready)
		else $error("row queue accepts a word while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_count != '0))
		else $error("row queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCntW'(QDepth))
		else $error("row queue count out of range");

endmodule

>>> hdl/hdtn_front.sv
// Front part: holds the mode register, takes rows and turns them into magnitudes.
// Depends on hdtn_pkg.
module hdtn_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [71:0]          s_tdata,
	input  logic                 s_tlast,
	input  logic                 q_full,
	output logic                 q_push,
	output hdtn_pkg::row_t       q_row
);
	import hdtn_pkg::*;

	logic [1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MAX;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_row.dmag   = abs_val(s_tdata[23:0]);
		q_row.re_mag = abs_val(s_tdata[47:24]);
		q_row.im_mag = abs_val(s_tdata[71:48]);
		q_row.last   = s_tlast;
		q_row.mode   = mode_q;
	end

endmodule

>>> hdl/hdtn_queue.sv
// Short row queue between the front and back parts.
// Depends on hdtn_pkg.
module hdtn_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  hdtn_pkg::row_t              wr_row,
	input  logic                        pop,
	output logic                        full,
	output logic                        rd_valid,
	output hdtn_pkg::row_t              rd_row,
	output logic [hdtn_pkg::QCntW-1:0]  count
);
	import hdtn_pkg::*;

	row_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= QPtrW'((32'(wr_q) + 1) % QDepth);
			if (pop)  rd_q <= QPtrW'((32'(rd_q) + 1) % QDepth);
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign full     = (cnt_q == QCntW'(QDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_row   = mem_q[rd_q];
	assign count    = cnt_q;

endmodule

>>> hdl/hdtn_isqrt.sv
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// Depends on hdtn_pkg.
module hdtn_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hdtn_pkg::SumW-1:0]   x,
	output logic                        done,
	output logic [hdtn_pkg::RootW-1:0]  root
);
	import hdtn_pkg::*;

	logic [SumW-1:0] rem_q;
	logic [SumW-1:0] res_q;
	logic [SumW-1:0] bit_q;
	logic            run_q;
	logic            done_q;
	logic [SumW-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q == SumW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= x;
			res_q <= '0;
			bit_q <= SumW'(1) << (SumW - 2);
		end else if (run_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[RootW-1:0];

endmodule

>>> hdl/hdtn_back.sv
// Back part: squares, accumulates, takes roots and keeps the running norm state.
// Depends on hdtn_pkg and hdtn_isqrt.
module hdtn_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  hdtn_pkg::row_t      q_row,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata
);
	import hdtn_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_SUMD, S_SUME, S_ROOTE, S_UPD, S_ROOTF, S_OUT
	} state_t;

	state_t           state_q;
	row_t             row_q;
	logic [47:0]      dsq_s1;
	logic [47:0]      resq_s1;
	logic [47:0]      imsq_s1;
	logic [48:0]      esq_q;
	logic [SumW-1:0]  sq_q;
	logic [NormW-1:0] best_q;
	logic [MagW-1:0]  prev_q;
	logic [MagW-1:0]  emag_q;
	logic [NormW-1:0] res_q;
	logic             ovalid_q;
	logic [NormW-1:0] odata_q;

	logic             rt_start;
	logic [SumW-1:0]  rt_x;
	logic             rt_done;
	logic [RootW-1:0] rt_root;

	logic [SumW-1:0]  addend;
	logic [SumW:0]    sum_wide;
	logic [SumW-1:0]  sq_sat;
	logic [MagW-1:0]  cand_max;
	logic [NormW-1:0] cand_one;
	logic [NormW-1:0] best_nxt;

	hdtn_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rt_start),
		.x      (rt_x),
		.done   (rt_done),
		.root   (rt_root)
	);

	assign rt_start = (state_q == S_SUME && !row_q.last) ||
	                  (state_q == S_UPD && row_q.last && row_q.mode == MODE_FROB);
	assign rt_x     = (state_q == S_SUME) ? SumW'(esq_q) : sq_q;

	always_comb begin
		addend   = (state_q == S_SUMD) ? SumW'(dsq_s1) : SumW'({esq_q, 1'b0});
		sum_wide = {1'b0, sq_q} + {1'b0, addend};
		sq_sat   = sum_wide[SumW] ? '1 : sum_wide[SumW-1:0];

		cand_max = (MagW'(row_q.dmag) > emag_q) ? MagW'(row_q.dmag) : emag_q;
		cand_one = NormW'(row_q.dmag) + NormW'(emag_q) + NormW'(prev_q);
		best_nxt = best_q;
		if (row_q.mode == MODE_MAX && NormW'(cand_max) > best_q) best_nxt = NormW'(cand_max);
		if (row_q.mode == MODE_ONE && cand_one > best_q)         best_nxt = cand_one;
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sq_q     <= '0;
			best_q   <= '0;
			prev_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (m_tready && state_q != S_OUT) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_SUMD;
				S_SUMD: begin
					sq_q    <= sq_sat;
					state_q <= S_SUME;
				end
				S_SUME: begin
					// the last row carries no off-diagonal term
					if (!row_q.last) begin
						sq_q    <= sq_sat;
						state_q <= S_ROOTE;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_ROOTE: begin
					if (rt_done) state_q <= S_UPD;
				end
				S_UPD: begin
					best_q <= best_nxt;
					prev_q <= emag_q;
					if (!row_q.last)                  state_q <= S_IDLE;
					else if (row_q.mode == MODE_FROB) state_q <= S_ROOTF;
					else                              state_q <= S_OUT;
				end
				S_ROOTF: begin
					if (rt_done) state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free, then clear for the next matrix
					if (!ovalid_q || m_tready) begin
						ovalid_q <= 1'b1;
						sq_q     <= '0;
						best_q   <= '0;
						prev_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) row_q <= q_row;
		if (state_q == S_MUL) begin
			dsq_s1  <= 48'(row_q.dmag) * 48'(row_q.dmag);
			resq_s1 <= 48'(row_q.re_mag) * 48'(row_q.re_mag);
			imsq_s1 <= 48'(row_q.im_mag) * 48'(row_q.im_mag);
		end
		if (state_q == S_SUMD) esq_q <= 49'(resq_s1) + 49'(imsq_s1);
		if (state_q == S_SUME) emag_q <= '0;
		if (state_q == S_ROOTE && rt_done) emag_q <= MagW'(rt_root);
		if (state_q == S_UPD) begin
			res_q <= (row_q.mode == MODE_MAX || row_q.mode == MODE_ONE) ? best_nxt : '0;
		end
		if (state_q == S_ROOTF && rt_done) begin
			res_q <= (rt_root[RootW-1:NormW] != '0) ? NormMax : rt_root[NormW-1:0];
		end
		if (state_q == S_OUT && (!ovalid_q || m_tready)) odata_q <= res_q;
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {2'b00, odata_q};

endmodule

>>> dv/tb_top.sv
// Self-checking bench for the Hermitian tridiagonal norm block.
// Depends on hdtn_pkg and hermitian_tridiagonal_norm; predicts each norm in the bench.
`timescale 1ns / 100ps

module tb_top;
	import hdtn_pkg::*;

	typedef struct {
		logic [23:0] diag;
		logic [23:0] re;
		logic [23:0] im;
		logic        last;
	} row_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	row_word_t   pending_rows[$];
	logic [29:0] expected_norms[$];
	int          error_count;
	logic        hold_sender;
	int          burst_left;
	int          gap_left;
	int          stall_phase;

	// predictor state
	logic [1:0]  mode_now;
	logic [29:0] best_so_far;
	logic [24:0] prev_emag;
	logic [63:0] sq_total;

	hermitian_tridiagonal_norm uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [63:0] floor_root(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	function automatic logic [63:0] mag24(input logic [23:0] v);
		return v[23] ? 64'h100_0000 - {40'd0, v} : {40'd0, v};
	endfunction

	// update the norm state with one accepted row; queue the norm on the last row
	task automatic absorb_row(input row_word_t r);
		logic [63:0] dmag, emag, esq, cand, res;
		dmag = mag24(r.diag);
		emag = 0;
		esq = 0;
		if (!r.last) begin
			esq = mag24(r.re) * mag24(r.re) + mag24(r.im) * mag24(r.im);
			emag = floor_root(esq) & 64'h1FF_FFFF;
		end
		sq_total = sat_sum(sq_total, dmag * dmag);
		if (!r.last) begin
			sq_total = sat_sum(sq_total, esq);
			sq_total = sat_sum(sq_total, esq);
		end
		if (mode_now == MODE_MAX) begin
			cand = (dmag > emag) ? dmag : emag;
			if (cand > best_so_far) best_so_far = cand[29:0];
		end else if (mode_now == MODE_ONE) begin
			cand = dmag + emag + prev_emag;
			if (cand > 64'h3FFF_FFFF) cand = 64'h3FFF_FFFF;
			if (cand > best_so_far) best_so_far = cand[29:0];
		end
		prev_emag = emag[24:0];
		if (r.last) begin
			if (mode_now == MODE_MAX || mode_now == MODE_ONE) begin
				res = best_so_far;
			end else if (mode_now == MODE_FROB) begin
				res = floor_root(sq_total);
				if (res > 64'h3FFF_FFFF) res = 64'h3FFF_FFFF;
			end else begin
				res = 0;
			end
			expected_norms.push_back(res[29:0]);
			best_so_far = 0;
			prev_emag = 0;
			sq_total = 0;
		end
	endtask

	function automatic logic [23:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2: return 24'h00_0000;
			3: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic add_matrix(input int rows);
		row_word_t r;
		for (int i = 0; i < rows; i++) begin
			r.diag = pick_value();
			r.re = pick_value();
			r.im = pick_value();
			r.last = (i == rows - 1);
			pending_rows.push_back(r);
		end
	endtask

	task automatic add_row(input logic [23:0] d, input logic [23:0] re,
			input logic [23:0] im, input logic last);
		row_word_t r;
		r.diag = d;
		r.re = re;
		r.im = im;
		r.last = last;
		pending_rows.push_back(r);
	endtask

	// wait for the block to drain, then write the mode
	task automatic set_mode(input logic [1:0] m);
		while (pending_rows.size() != 0 || expected_norms.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_now = m;
	endtask

	// driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				absorb_row(pending_rows.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) gap_left--;
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
				if (pending_rows.size() != 0 && !hold_sender && burst_left > 0
						&& (gap_left == 0 || $urandom_range(0, 1) == 0)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {pending_rows[0].im, pending_rows[0].re, pending_rows[0].diag};
					s_tlast <= pending_rows[0].last;
					burst_left--;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_norms.size() == 0) begin
					$display("%0t: unexpected norm, expected none, actual %0d", $realtime,
						m_tdata[29:0]);
					error_count++;
				end else begin
					logic [29:0] want;
					want = expected_norms.pop_front();
					if (m_tdata[29:0] !== want || m_tdata[31:30] !== 2'b00) begin
						$display("%0t: norm mismatch, expected %0d, actual %0d (tdata %h)",
							$realtime, want, m_tdata[29:0], m_tdata);
						error_count++;
					end
				end
			end
			stall_phase = (stall_phase + 1) % 23;
			m_tready <= (stall_phase < 7) ? 1'b1 : (stall_phase < 15) ? ($urandom_range(0, 3) != 0)
				: (stall_phase < 19) ? 1'b0 : 1'b1;
		end
	end

	initial begin
		#60_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int total;
		error_count = 0;
		hold_sender = 1'b0;
		mode_now = MODE_MAX;
		best_so_far = 0;
		prev_emag = 0;
		sq_total = 0;
		cfg_we = 1'b0;
		cfg_wdata = 2'd0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single rows, extremes, mode three, then a two-row matrix in one-norm mode
		for (int m = 0; m < 4; m++) begin
			set_mode(2'(m));
			add_row(24'h80_0000, 24'h00_0000, 24'h00_0000, 1'b1);
			add_row(24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 1'b0);
			add_row(24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 1'b0);
			add_row(24'h00_0000, 24'h12_3456, 24'hFE_DCBA, 1'b1);
		end
		set_mode(MODE_ONE);
		add_row(24'h01_0000, 24'h03_0000, 24'h04_0000, 1'b0);
		add_row(24'hFF_0000, 24'h00_0000, 24'h00_0000, 1'b1);
		// pause the sender until every outstanding norm has come back
		while (pending_rows.size() != 0) @(posedge clk);
		hold_sender = 1'b1;
		while (expected_norms.size() != 0) @(posedge clk);
		hold_sender = 1'b0;
		set_mode(MODE_FROB);

		// random matrices, mostly short, some long; mode switches in between
		total = 0;
		while (total < 1530) begin
			int rows;
			if ($urandom_range(0, 9) == 0) set_mode(2'($urandom_range(0, 3)));
			if ($urandom_range(0, 29) == 0) begin
				hold_sender = 1'b1;
				while (expected_norms.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			rows = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
			add_matrix(rows);
			total += rows;
			while (pending_rows.size() > 16) @(posedge clk);
		end

		while (pending_rows.size() != 0 || expected_norms.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
